// ----- src/pid_controller_step_assert.svh -----
// assertion macros for the pid controller step block
// expects i_clk and i_rst_n in the scope of the module that includes it
`ifndef PID_CONTROLLER_STEP_ASSERT_SVH
`define PID_CONTROLLER_STEP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PIDC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pidc: same-cycle check failed");

// next-cycle implication, checked outside reset
`define PIDC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pidc: next-cycle check failed");

`endif

// ----- src/pidc_pkg.sv -----
// shared types, register codes and saturation helper for the pid controller step
// no dependencies
`default_nettype none

package pidc_pkg;

    // word carried on the sample channel
    typedef struct packed {
        logic signed [31:0] measurement;
    } t_in_word;

    // word carried on the result channel
    typedef struct packed {
        logic signed [31:0] drive;
        logic               at_setpoint;
    } t_out_word;

    // configuration register index
    localparam int unsigned CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] CFG_SET_POINT     = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_GAIN_P        = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_GAIN_I        = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_GAIN_D        = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_SAMPLE_PERIOD = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_INV_PERIOD    = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_ERR_THRESHOLD = 3'd6;

    // register reset values, q16.16
    localparam logic signed [31:0] RST_SET_POINT     = 32'sd0;
    localparam logic signed [31:0] RST_GAIN_P        = 32'sd655360;
    localparam logic signed [31:0] RST_GAIN_I        = 32'sd0;
    localparam logic signed [31:0] RST_GAIN_D        = 32'sd65536;
    localparam logic [30:0]        RST_SAMPLE_PERIOD = 31'd66;
    localparam logic [30:0]        RST_INV_PERIOD    = 31'd65536000;
    localparam logic signed [31:0] RST_ERR_THRESHOLD = 32'sd66;

    // clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [31:0] sat_s32(input logic signed [51:0] v);
        logic signed [51:0] hi;
        logic signed [51:0] lo;
        hi = 52'sd2147483647;
        lo = -52'sd2147483648;
        if (v > hi) begin
            sat_s32 = 32'sh7fff_ffff;
        end else if (v < lo) begin
            sat_s32 = 32'sh8000_0000;
        end else begin
            sat_s32 = v[31:0];
        end
    endfunction

endpackage

`default_nettype wire

// ----- src/pidc_word_if.sv -----
// valid/ready channel carrying one word of a chosen payload type
// no dependencies; payload types come from pidc_pkg at instantiation
`default_nettype none

interface pidc_word_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- src/pid_controller_step.sv -----
// pid controller step, parallel form, signed q16.16, one shared multiplier
// depends on pidc_pkg, pidc_word_if and pid_controller_step_assert.svh
//
//  channel   dir   payload                          handshake
//  i_meas    in    measurement  s32 q16.16          valid/ready
//  o_res     out   drive s32 q16.16, at_setpoint    valid/ready
//  i_cfg_*   in    register index, 32-bit data      write enable only
//
// a sample steps through mul_i, mul_d, mul_p, mul_ii and mul_dd to done, and no new
// sample is taken before idle: the five products go one per cycle through a single
// 33x33 signed multiplier, then the sum is saturated.
// ready is high only while the sequencer is idle.
// the result register holds the previous word while a new sample is worked;
// the sequencer waits in its last step while that register is still full.
// synchronous active-low reset restores register defaults and clears state.
`default_nettype none

module pid_controller_step
    import pidc_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    pidc_word_if.sink           i_meas,
    pidc_word_if.source         o_res,
    input  wire                 i_cfg_we,
    input  wire [CfgIdxW-1:0]   i_cfg_idx,
    input  wire [31:0]          i_cfg_wdata
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_MUL_I  = 7'b0000010,
        S_MUL_D  = 7'b0000100,
        S_MUL_P  = 7'b0001000,
        S_MUL_II = 7'b0010000,
        S_MUL_DD = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic signed [31:0] r_set_point, r_gain_p, r_gain_i, r_gain_d, r_err_thresh;
    logic        [30:0] r_period, r_inv_period;

    // controller state and working registers
    logic signed [31:0] r_integral, r_last_err, r_err, r_deriv;
    logic signed [32:0] r_diff;
    logic signed [63:0] r_prod;
    logic signed [51:0] r_acc;
    logic               r_flag;
    t_out_word          r_out;
    logic               r_out_valid;

    logic signed [32:0] w_err_wide;
    logic signed [31:0] w_err_sat;
    logic signed [32:0] w_mul_a, w_mul_b;
    logic signed [65:0] w_prod;
    logic signed [47:0] w_q;
    logic signed [51:0] w_int_sum, w_drive_sum;
    logic               w_accept, w_load_out;

    assign w_accept   = i_meas.valid && i_meas.ready;
    assign w_load_out = (r_state == S_DONE) && (!r_out_valid || o_res.ready);

    // error from the incoming word, exact and clamped
    assign w_err_wide = 33'(r_set_point) - 33'(i_meas.payload.measurement);
    assign w_err_sat  = sat_s32(52'(w_err_wide));

    // shared multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            S_MUL_I: begin
                w_mul_a = 33'(r_err);
                w_mul_b = $signed({2'b00, r_period});
            end
            S_MUL_D: begin
                w_mul_a = r_diff;
                w_mul_b = $signed({2'b00, r_inv_period});
            end
            S_MUL_P: begin
                w_mul_a = 33'(r_err);
                w_mul_b = 33'(r_gain_p);
            end
            S_MUL_II: begin
                w_mul_a = 33'(r_integral);
                w_mul_b = 33'(r_gain_i);
            end
            S_MUL_DD: begin
                w_mul_a = 33'(r_deriv);
                w_mul_b = 33'(r_gain_d);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // registered product shifted down by 16, rounding toward minus infinity
    assign w_q         = $signed(r_prod[63:16]);
    assign w_int_sum   = 52'(r_integral) + 52'(w_q);
    assign w_drive_sum = r_acc + 52'(w_q);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (w_accept) n_state = S_MUL_I;
            S_MUL_I:  n_state = S_MUL_D;
            S_MUL_D:  n_state = S_MUL_P;
            S_MUL_P:  n_state = S_MUL_II;
            S_MUL_II: n_state = S_MUL_DD;
            S_MUL_DD: n_state = S_DONE;
            S_DONE:   if (w_load_out) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control state, configuration and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_integral   <= '0;
            r_last_err   <= '0;
            r_set_point  <= RST_SET_POINT;
            r_gain_p     <= RST_GAIN_P;
            r_gain_i     <= RST_GAIN_I;
            r_gain_d     <= RST_GAIN_D;
            r_period     <= RST_SAMPLE_PERIOD;
            r_inv_period <= RST_INV_PERIOD;
            r_err_thresh <= RST_ERR_THRESHOLD;
        end else begin
            r_state <= n_state;

            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            if (r_state == S_MUL_D) begin
                r_integral <= sat_s32(w_int_sum);
            end
            if (w_load_out) begin
                r_last_err <= r_err;
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SET_POINT:     r_set_point  <= $signed(i_cfg_wdata);
                    CFG_GAIN_P:        r_gain_p     <= $signed(i_cfg_wdata);
                    CFG_GAIN_I:        r_gain_i     <= $signed(i_cfg_wdata);
                    CFG_GAIN_D:        r_gain_d     <= $signed(i_cfg_wdata);
                    CFG_SAMPLE_PERIOD: r_period     <= i_cfg_wdata[30:0];
                    CFG_INV_PERIOD:    r_inv_period <= i_cfg_wdata[30:0];
                    CFG_ERR_THRESHOLD: r_err_thresh <= $signed(i_cfg_wdata);
                    default: ;
                endcase
            end
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_err  <= w_err_sat;
            r_flag <= (w_err_wide <= 33'(r_err_thresh));
        end
        if (r_state == S_MUL_I) begin
            r_diff <= 33'(r_err) - 33'(r_last_err);
        end
        // product register holds while idle or waiting to hand off
        if (r_state != S_IDLE && r_state != S_DONE) begin
            r_prod <= $signed(w_prod[63:0]);
        end
        if (r_state == S_MUL_P) begin
            r_deriv <= sat_s32(52'(w_q));
        end
        if (r_state == S_MUL_II) begin
            r_acc <= 52'(w_q);
        end
        if (r_state == S_MUL_DD) begin
            r_acc <= w_drive_sum;
        end
        if (w_load_out) begin
            r_out.drive       <= sat_s32(w_drive_sum);
            r_out.at_setpoint <= r_flag;
        end
    end

    assign i_meas.ready  = (r_state == S_IDLE);
    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    // checks
    `include "pid_controller_step_assert.svh"

    `PIDC_ASSERT_NEXT(a_accept_starts_seq, w_accept, r_state == S_MUL_I)
    `PIDC_ASSERT_NEXT(a_integral_only_in_step, r_state != S_MUL_D, $stable(r_integral))
    `PIDC_ASSERT_NEXT(a_last_err_only_on_handoff, !w_load_out, $stable(r_last_err))
    `PIDC_ASSERT_NOW(a_result_from_done, $rose(r_out_valid), $past(r_state == S_DONE))

endmodule

`default_nettype wire

// ----- bench/tb_pid_controller_step.sv -----
`timescale 1ns / 1ps
// self-checking bench for pid_controller_step: random samples and register settings
// depends on pidc_pkg, pidc_word_if and the pid_controller_step rtl

module tb_pid_controller_step;
    import pidc_pkg::*;

    localparam logic [CfgIdxW-1:0] CFG_UNUSED = 3'd7;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_idx;
    logic [31:0]         i_cfg_wdata;

    pidc_word_if #(.t_payload(t_in_word))  meas_if ();
    pidc_word_if #(.t_payload(t_out_word)) res_if ();

    pid_controller_step i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_meas      (meas_if),
        .o_res       (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // mirror of the controller registers and state
    logic signed [31:0] m_set_point;
    logic signed [31:0] m_gain_p;
    logic signed [31:0] m_gain_i;
    logic signed [31:0] m_gain_d;
    logic [30:0]        m_period;
    logic [30:0]        m_inv_period;
    logic signed [31:0] m_threshold;
    logic signed [31:0] m_integral;
    logic signed [31:0] m_last_err;

    logic [31:0] sample_q[$];
    t_out_word   drive_q[$];
    logic        meas_taken;
    logic        calm;
    int unsigned mismatches;

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic signed [31:0] clamp_s32(input logic signed [79:0] v);
        if (v > 80'sd2147483647) return 32'sh7fff_ffff;
        if (v < -80'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // one controller step: updates integral and last error, returns the result word
    function automatic t_out_word next_drive(input logic signed [31:0] meas);
        logic signed [32:0] err_wide;
        logic signed [31:0] err;
        logic signed [31:0] deriv;
        logic signed [79:0] prod;
        logic signed [79:0] sum;
        t_out_word          w;
        err_wide = 33'(m_set_point) - 33'(meas);
        err = clamp_s32(80'(err_wide));
        prod = 80'(err) * 80'($signed({1'b0, m_period}));
        m_integral = clamp_s32(80'(m_integral) + (prod >>> 16));
        prod = (80'(err) - 80'(m_last_err)) * 80'($signed({1'b0, m_inv_period}));
        deriv = clamp_s32(prod >>> 16);
        sum = ((80'(err) * 80'(m_gain_p)) >>> 16)
            + ((80'(m_integral) * 80'(m_gain_i)) >>> 16)
            + ((80'(deriv) * 80'(m_gain_d)) >>> 16);
        w.drive = clamp_s32(sum);
        w.at_setpoint = (err_wide <= 33'(m_threshold));
        m_last_err = err;
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // register mirror, prediction on accepted samples, result check
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            m_set_point  = RST_SET_POINT;
            m_gain_p     = RST_GAIN_P;
            m_gain_i     = RST_GAIN_I;
            m_gain_d     = RST_GAIN_D;
            m_period     = RST_SAMPLE_PERIOD;
            m_inv_period = RST_INV_PERIOD;
            m_threshold  = RST_ERR_THRESHOLD;
            m_integral   = '0;
            m_last_err   = '0;
            meas_taken  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SET_POINT:     m_set_point  = i_cfg_wdata;
                    CFG_GAIN_P:        m_gain_p     = i_cfg_wdata;
                    CFG_GAIN_I:        m_gain_i     = i_cfg_wdata;
                    CFG_GAIN_D:        m_gain_d     = i_cfg_wdata;
                    CFG_SAMPLE_PERIOD: m_period     = i_cfg_wdata[30:0];
                    CFG_INV_PERIOD:    m_inv_period = i_cfg_wdata[30:0];
                    CFG_ERR_THRESHOLD: m_threshold  = i_cfg_wdata;
                    default: ;
                endcase
            end
            meas_taken <= meas_if.valid && meas_if.ready;
            if (meas_if.valid && meas_if.ready) begin
                drive_q.push_back(next_drive(meas_if.payload.measurement));
            end
            if (res_if.valid && res_if.ready) begin
                if (drive_q.size() == 0) begin
                    report_mismatch("unexpected word", res_if.payload.drive, '0);
                end else begin
                    want = drive_q.pop_front();
                    if (res_if.payload.drive !== want.drive)
                        report_mismatch("drive", res_if.payload.drive, want.drive);
                    if (res_if.payload.at_setpoint !== want.at_setpoint)
                        report_mismatch("at_setpoint", 32'(res_if.payload.at_setpoint),
                                        32'(want.at_setpoint));
                end
            end
        end
    end

    // sample driver and result back-pressure, both change on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            meas_if.valid <= 1'b0;
            res_if.ready  <= 1'b0;
        end else begin
            if (!meas_if.valid || meas_taken) begin
                if (sample_q.size() != 0 && (calm || $urandom_range(99) >= 15)) begin
                    meas_if.payload.measurement <= sample_q.pop_front();
                    meas_if.valid <= 1'b1;
                end else begin
                    meas_if.valid <= 1'b0;
                end
            end
            res_if.ready <= calm || ($urandom_range(99) >= 15);
        end
    end

    task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // wait until every sample went in and every result came back
    task automatic wait_drained();
        while (sample_q.size() != 0 || meas_if.valid || drive_q.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // q16.16 value: extremes, zero, moderate magnitudes or any pattern
    function automatic logic [31:0] pick_q16();
        case ($urandom_range(7))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return $urandom;
            3:       return '0;
            default: return 32'($signed($urandom) >>> $urandom_range(16, 8));
        endcase
    endfunction

    // period register value; bit 31 is written as noise at times
    function automatic logic [31:0] pick_period(input int unsigned typical);
        case ($urandom_range(7))
            0:       return 32'h7fff_ffff;
            1:       return {1'b1, 31'($urandom_range(1, 0))};
            2:       return $urandom;
            default: return 32'($urandom_range(typical, 1));
        endcase
    endfunction

    // measurement: mostly near the set point, sometimes anywhere or at the rails
    function automatic logic [31:0] pick_measurement();
        case ($urandom_range(9))
            0:       return ($urandom_range(1)) ? 32'h7fff_ffff : 32'h8000_0000;
            1, 2:    return $urandom;
            default: return m_set_point + 32'($signed($urandom) >>> $urandom_range(31, 8));
        endcase
    endfunction

    task automatic program_random_settings();
        if ($urandom_range(3) != 0) write_register(CFG_SET_POINT, pick_q16());
        if ($urandom_range(3) != 0) write_register(CFG_GAIN_P, pick_q16());
        if ($urandom_range(3) != 0) write_register(CFG_GAIN_I, pick_q16());
        if ($urandom_range(3) != 0) write_register(CFG_GAIN_D, pick_q16());
        if ($urandom_range(3) != 0) write_register(CFG_SAMPLE_PERIOD, pick_period(2000));
        if ($urandom_range(3) != 0) write_register(CFG_INV_PERIOD, pick_period(1 << 26));
        if ($urandom_range(3) != 0) write_register(CFG_ERR_THRESHOLD, pick_q16());
        if ($urandom_range(9) == 0) write_register(CFG_UNUSED, $urandom);
    endtask

    // stimulus
    initial begin
        i_rst_n                     = 1'b0;
        i_cfg_we                    = 1'b0;
        i_cfg_idx                   = CFG_SET_POINT;
        i_cfg_wdata                 = '0;
        meas_if.valid               = 1'b0;
        meas_if.payload.measurement = '0;
        res_if.ready                = 1'b0;
        calm                        = 1'b0;
        mismatches                  = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: rails, big swings for the derivative, threshold edge
        sample_q = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                     32'h7fff_ffff, 32'd66, -32'sd66, -32'sd67, 32'h0001_0000,
                     32'hffff_0000};
        wait_drained();

        // top end, gain_i and threshold at the bottom: error, integral, derivative, drive overflow
        write_register(CFG_SET_POINT, 32'h7fff_ffff);
        write_register(CFG_GAIN_P, 32'h7fff_ffff);
        write_register(CFG_GAIN_I, 32'h8000_0000);
        write_register(CFG_GAIN_D, 32'h7fff_ffff);
        write_register(CFG_SAMPLE_PERIOD, 32'h7fff_ffff);
        write_register(CFG_INV_PERIOD, 32'h7fff_ffff);
        write_register(CFG_ERR_THRESHOLD, 32'h8000_0000);
        sample_q = '{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h8000_0000};
        wait_drained();

        // bottom end, threshold at the top, zero periods written through bit 31, unknown index ignored
        write_register(CFG_SET_POINT, 32'h8000_0000);
        write_register(CFG_GAIN_P, 32'h8000_0000);
        write_register(CFG_GAIN_I, 32'h8000_0000);
        write_register(CFG_GAIN_D, 32'h8000_0000);
        write_register(CFG_SAMPLE_PERIOD, 32'h8000_0000);
        write_register(CFG_INV_PERIOD, 32'h8000_0000);
        write_register(CFG_ERR_THRESHOLD, 32'h7fff_ffff);
        write_register(CFG_UNUSED, 32'hffff_ffff);
        sample_q = '{32'h7fff_ffff, 32'h8000_0000, 32'h0};
        wait_drained();

        // random settings, one phase without any idling
        for (int phase = 0; phase < 12; phase++) begin
            program_random_settings();
            calm = (phase == 5);
            for (int n = 0; n < 108; n++) sample_q.push_back(pick_measurement());
            wait_drained();
            calm = 1'b0;
        end

        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS pid_controller_step");
        end else begin
            $display("FAIL pid_controller_step");
        end
        $finish;
    end

    // run limit
    initial begin
        #5ms;
        $display("FAIL pid_controller_step");
        $finish;
    end

endmodule
